/* rtl/utf8_sanitizer_top_assert.svh */
// utf8_sanitizer_top_assert.svh
// Assertion macros used by the checker file of the sanitizer.
`ifndef UTF8_SANITIZER_TOP_ASSERT_SVH
`define UTF8_SANITIZER_TOP_ASSERT_SVH

// Property checked only while out of reset.
`define U8S_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define U8S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/utf8s_pkg.sv */
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types and constants shared by the UTF-8 sanitizer modules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Byte constants
  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] MASK_2B   = 8'hE0;
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] MASK_3B   = 8'hF0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] MASK_4B   = 8'hF8;
  localparam logic [7:0] LEAD_4B   = 8'hF0;
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [7:0] MIN_2B    = 8'hC2;
  localparam logic [7:0] MIN_E0_B1 = 8'hA0;
  localparam logic [7:0] MIN_F0_B1 = 8'h90;
  localparam logic [7:0] MAX_4B    = 8'hF4;

  // Classifier result for the byte at the head of the work buffer
  typedef struct packed {
    logic       bad;       // zero, stray continuation or F8..FF
    logic       ascii;     // 01..7F
    logic [2:0] form_len;  // 2..4 for a lead, else 0
    logic       seq_ok;    // full sequence passes (when present)
  } chk_res_t;

  // Command from the sequencer to the output stage
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       flush;
    logic       flush_last;
  } ostg_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

/* rtl/utf8s_check.sv */
// ----------------------------------------------------------------------------
// utf8s_check
// Classifies the head byte of the work buffer and checks the sequence it leads.
// ----------------------------------------------------------------------------
module utf8s_check (
  input  logic [3:0][7:0]     buf_bytes,
  output utf8s_pkg::chk_res_t res
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic       c1_ok;
  logic       c2_ok;
  logic       c3_ok;

  assign b0    = buf_bytes[0];
  assign b1    = buf_bytes[1];
  assign c1_ok = (buf_bytes[1][7:6] == utf8s_pkg::CONT_TAG);
  assign c2_ok = (buf_bytes[2][7:6] == utf8s_pkg::CONT_TAG);
  assign c3_ok = (buf_bytes[3][7:6] == utf8s_pkg::CONT_TAG);

  // Form length, byte class and sequence checks
  always_comb begin
    res = '0;
    if ((b0 & utf8s_pkg::MASK_2B) == utf8s_pkg::LEAD_2B) begin
      res.form_len = 3'd2;
    end else if ((b0 & utf8s_pkg::MASK_3B) == utf8s_pkg::LEAD_3B) begin
      res.form_len = 3'd3;
    end else if ((b0 & utf8s_pkg::MASK_4B) == utf8s_pkg::LEAD_4B) begin
      res.form_len = 3'd4;
    end else begin
      res.form_len = 3'd0;
    end

    res.bad   = (b0 == 8'h00) || (b0[7] && (res.form_len == 3'd0));
    res.ascii = !b0[7] && (b0 != 8'h00);

    case (res.form_len)
      3'd2: begin
        res.seq_ok = c1_ok && (b0 >= utf8s_pkg::MIN_2B);
      end
      3'd3: begin
        res.seq_ok = c1_ok && c2_ok &&
                     !((b0 == utf8s_pkg::LEAD_3B) && (b1 < utf8s_pkg::MIN_E0_B1));
      end
      3'd4: begin
        res.seq_ok = c1_ok && c2_ok && c3_ok &&
                     !((b0 == utf8s_pkg::LEAD_4B) && (b1 < utf8s_pkg::MIN_F0_B1)) &&
                     (b0 <= utf8s_pkg::MAX_4B);
      end
      default: begin
        res.seq_ok = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/utf8s_ostg.sv */
// ----------------------------------------------------------------------------
// utf8s_ostg
// Output stage: one pending byte plus the output register. The pending byte
// is released once the next byte or the end of the scan is known, so the end
// mark lands on the right item.
// ----------------------------------------------------------------------------
module utf8s_ostg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8s_pkg::ostg_cmd_t cmd,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8s_pkg::out_item_t out_item
);

  logic                 pend_v_r;
  logic                 pend_v_nxt;
  logic [7:0]           pend_b_r;
  logic [7:0]           pend_b_nxt;
  logic                 out_v_r;
  logic                 out_v_nxt;
  utf8s_pkg::out_item_t out_item_r;
  utf8s_pkg::out_item_t out_item_nxt;

  // Output slot can take a new item this cycle
  assign free      = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // Next-state logic
  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_b_nxt   = pend_b_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_item_nxt = out_item_r;
    if (cmd.push) begin
      if (pend_v_r) begin
        out_v_nxt             = 1'b1;
        out_item_nxt.out_byte = pend_b_r;
        out_item_nxt.out_last = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_b_nxt = cmd.push_byte;
    end else if (cmd.flush && pend_v_r) begin
      out_v_nxt             = 1'b1;
      out_item_nxt.out_byte = pend_b_r;
      out_item_nxt.out_last = cmd.flush_last;
      pend_v_nxt            = 1'b0;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_b_r   <= pend_b_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

/* rtl/utf8_sanitizer_top.sv */
// ----------------------------------------------------------------------------
// utf8_sanitizer_top
// Streaming UTF-8 cleaner. Bytes go in one item at a time on in_*, cleaned
// bytes come out on out_*, and invalid bytes are replaced by '?'.
//
// Input items are taken when in_valid and in_ready are high; in_ready is high
// only while the sequencer is idle. Each accepted byte is appended to a
// four-byte shift buffer (holding any unfinished lead from earlier items) and
// the buffer is scanned through a single classifier, one byte per cycle
// while the output register can take a byte. After the accept, each byte an
// item releases (0 to 4) is scanned in turn, and a closing step flushes the
// pending byte and returns the sequencer to idle.
// An incomplete lead without an end mark stays buffered and gives no output.
// Output items are held in a register; while it is full and out_ready is low
// the scan stalls and, once idle, the next input may still be accepted.
// After reset nothing is buffered, no output is valid and in_ready is high.
// ----------------------------------------------------------------------------
module utf8_sanitizer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8s_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8s_pkg::out_item_t out_item
);

  utf8s_pkg::state_t    state_r;
  utf8s_pkg::state_t    state_nxt;
  logic [3:0][7:0]      buf_r;
  logic [3:0][7:0]      buf_nxt;
  logic [2:0]           n_r;
  logic [2:0]           n_nxt;
  logic [1:0]           rem_r;
  logic [1:0]           rem_nxt;
  logic                 last_r;
  logic                 last_nxt;
  utf8s_pkg::chk_res_t  chk;
  utf8s_pkg::ostg_cmd_t cmd;
  logic                 free;

  assign in_ready = (state_r == utf8s_pkg::ST_IDLE);

  // Shared classifier on the head of the buffer
  utf8s_check u_check (
    .buf_bytes (buf_r),
    .res       (chk)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      utf8s_pkg::ST_IDLE: begin
        if (in_valid) begin
          buf_nxt[n_r[1:0]] = in_item.in_byte;
          n_nxt             = n_r + 3'd1;
          last_nxt          = in_item.in_last;
          state_nxt         = utf8s_pkg::ST_SCAN;
        end
      end
      utf8s_pkg::ST_SCAN: begin
        if (free) begin
          if (rem_r != 2'd0) begin
            // continuation bytes of an accepted sequence
            cmd.push      = 1'b1;
            cmd.push_byte = buf_r[0];
            buf_nxt       = buf_r >> 8;
            n_nxt         = n_r - 3'd1;
            rem_nxt       = rem_r - 2'd1;
          end else if (n_r == 3'd0) begin
            // buffer drained: release the pending byte
            cmd.flush      = 1'b1;
            cmd.flush_last = last_r;
            state_nxt      = utf8s_pkg::ST_IDLE;
          end else if (chk.bad) begin
            cmd.push      = 1'b1;
            cmd.push_byte = utf8s_pkg::QMARK;
            buf_nxt       = buf_r >> 8;
            n_nxt         = n_r - 3'd1;
          end else if (chk.ascii) begin
            cmd.push      = 1'b1;
            cmd.push_byte = buf_r[0];
            buf_nxt       = buf_r >> 8;
            n_nxt         = n_r - 3'd1;
          end else if (chk.form_len > n_r) begin
            if (last_r) begin
              // truncated at end of text: one '?', rest dropped
              cmd.push      = 1'b1;
              cmd.push_byte = utf8s_pkg::QMARK;
              n_nxt         = 3'd0;
            end else begin
              // keep the partial sequence for the next item
              cmd.flush      = 1'b1;
              cmd.flush_last = 1'b0;
              state_nxt      = utf8s_pkg::ST_IDLE;
            end
          end else if (!chk.seq_ok) begin
            // reject the lead only, rescan what follows
            cmd.push      = 1'b1;
            cmd.push_byte = utf8s_pkg::QMARK;
            buf_nxt       = buf_r >> 8;
            n_nxt         = n_r - 3'd1;
          end else begin
            cmd.push      = 1'b1;
            cmd.push_byte = buf_r[0];
            buf_nxt       = buf_r >> 8;
            n_nxt         = n_r - 3'd1;
            rem_nxt       = 2'(chk.form_len - 3'd1);
          end
        end
      end
      default: begin
        state_nxt = utf8s_pkg::ST_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8s_pkg::ST_IDLE;
      n_r     <= 3'd0;
      rem_r   <= 2'd0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      rem_r   <= rem_nxt;
      last_r  <= last_nxt;
    end
    buf_r <= buf_nxt;
  end

  // Pending byte and output register
  utf8s_ostg u_ostg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* rtl/utf8s_chk.sv */
// ----------------------------------------------------------------------------
// utf8s_chk
// Port-level checks for the sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_top_assert.svh"

module utf8s_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input utf8s_pkg::out_item_t out_item
);

  // stalled output item holds
  `U8S_ASSERT_ON(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "output item changed while stalled")

  // an accepted item always starts a scan
  `U8S_ASSERT_ON(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")

  // output only appears out of a scan
  `U8S_ASSERT_ON(a_out_from_scan, $rose(out_valid) |-> $past(!in_ready), "output without a scan")

  // reset empties the block
  `U8S_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready, "block not empty after reset")

endmodule

bind utf8_sanitizer_top utf8s_chk u_utf8s_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
